FILE: rtl/dmn_pkg.sv
// ----------------------------------------------------------------------------
// dmn_pkg
// Types, codes and helpers shared by the mutual exclusion node modules.
// ----------------------------------------------------------------------------
package dmn_pkg;

    // rank space that dest and source can name
    localparam int RANK_BITS  = 3;
    localparam int RANK_SLOTS = 8;
    localparam int STAMP_BITS = 16;

    // configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_OWN_RANK   = 1'b1;

    // input opcodes
    localparam logic [2:0] OP_LOCAL_REQ = 3'd0;
    localparam logic [2:0] OP_LOCAL_REL = 3'd1;
    localparam logic [2:0] OP_GOT_REQ   = 3'd2;
    localparam logic [2:0] OP_GOT_REPLY = 3'd3;
    localparam logic [2:0] OP_GOT_REL   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_ENTER   = 2'd3;

    // input item
    typedef struct packed {
        logic [2:0]            opcode;
        logic [RANK_BITS-1:0]  source;
        logic [STAMP_BITS-1:0] msg_stamp;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]            kind;
        logic [RANK_BITS-1:0]  dest;
        logic [STAMP_BITS-1:0] stamp;
        logic                  last;
    } t_out_item;

    // work handed from the front to the back: a first group of messages,
    // then an optional group of release messages
    typedef struct packed {
        logic [RANK_SLOTS-1:0] first_mask;
        logic [1:0]            first_kind;
        logic [RANK_SLOTS-1:0] second_mask;
        logic [STAMP_BITS-1:0] stamp;
    } t_job;

    // index of the lowest set bit
    function automatic logic [RANK_BITS-1:0] lowest_rank(input logic [RANK_SLOTS-1:0] mask);
        logic [RANK_BITS-1:0] idx;
        idx = '0;
        for (int i = RANK_SLOTS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = RANK_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/dmn_queue.sv
// ----------------------------------------------------------------------------
// dmn_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module dmn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dmn_pkg::t_job i_job,
    input  logic          i_pop,
    output dmn_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    dmn_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/dmn_front.sv
// ----------------------------------------------------------------------------
// dmn_front
// Accepts items, keeps the Lamport clock and protocol state, and queues the
// messages each item causes as one job.
// ----------------------------------------------------------------------------
module dmn_front #(
    parameter int MAX_NODES  = 8,
    parameter int CLOCK_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_accept,
    input  dmn_pkg::t_in_item i_item,
    output logic              o_push,
    output dmn_pkg::t_job     o_job
);

    localparam int         WB         = (CLOCK_BITS > dmn_pkg::STAMP_BITS) ?
                                        CLOCK_BITS : dmn_pkg::STAMP_BITS;
    localparam int         LIMIT_INT  = (MAX_NODES < dmn_pkg::RANK_SLOTS) ?
                                        MAX_NODES : dmn_pkg::RANK_SLOTS;
    localparam logic [3:0] NODE_LIMIT = 4'(LIMIT_INT);
    localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = {CLOCK_BITS{1'b1}};

    logic [3:0]                    r_node_count;
    logic [dmn_pkg::RANK_BITS-1:0] r_own_rank;
    logic [CLOCK_BITS-1:0]         r_clock,     n_clock;
    logic [CLOCK_BITS-1:0]         r_req_stamp, n_req_stamp;
    logic                          r_wanting,   n_wanting;
    logic                          r_inside,    n_inside;
    logic [2:0]                    r_grant,     n_grant;
    logic [dmn_pkg::RANK_SLOTS-1:0] r_deferred, n_deferred;

    logic [3:0]                     live_n;
    logic [3:0]                     other_cnt;
    logic [dmn_pkg::RANK_SLOTS-1:0] lt_n;
    logic [dmn_pkg::RANK_SLOTS-1:0] others;
    logic [dmn_pkg::RANK_SLOTS-1:0] src_bit;
    logic [WB-1:0]                  stamp_ext;
    logic [CLOCK_BITS-1:0]          s_sat;
    logic [CLOCK_BITS-1:0]          rx_max;
    logic [CLOCK_BITS-1:0]          rx_clock;
    logic [CLOCK_BITS-1:0]          loc_clock;
    logic                           defer_req;

    // clamp the node count and build the rank masks
    always_comb begin
        live_n = r_node_count;
        if (live_n < 4'd2) begin
            live_n = 4'd2;
        end
        if (live_n > NODE_LIMIT) begin
            live_n = NODE_LIMIT;
        end
        for (int i = 0; i < dmn_pkg::RANK_SLOTS; i++) begin
            lt_n[i] = (4'(i) < live_n);
        end
        others    = lt_n & ~(dmn_pkg::RANK_SLOTS'(1) << r_own_rank);
        other_cnt = ({1'b0, r_own_rank} < live_n) ? live_n - 4'd1 : live_n;
        src_bit   = dmn_pkg::RANK_SLOTS'(1) << i_item.source;
    end

    // clock updates: received max+1 and local +1, both saturating
    always_comb begin
        stamp_ext = WB'(i_item.msg_stamp);
        s_sat     = (stamp_ext > WB'(CLOCK_MAX)) ? CLOCK_MAX : CLOCK_BITS'(stamp_ext);
        rx_max    = (r_clock > s_sat) ? r_clock : s_sat;
        rx_clock  = (rx_max == CLOCK_MAX) ? CLOCK_MAX : rx_max + CLOCK_BITS'(1);
        loc_clock = (r_clock == CLOCK_MAX) ? CLOCK_MAX : r_clock + CLOCK_BITS'(1);
        defer_req = r_inside ||
                    (r_wanting && ((r_req_stamp < s_sat) ||
                                   ((r_req_stamp == s_sat) &&
                                    (r_own_rank < i_item.source))));
    end

    // classify the item, update state and form its job
    always_comb begin
        n_clock     = r_clock;
        n_req_stamp = r_req_stamp;
        n_wanting   = r_wanting;
        n_inside    = r_inside;
        n_grant     = r_grant;
        n_deferred  = r_deferred;
        o_push      = 1'b0;
        o_job       = '0;
        if (i_accept) begin
            unique case (i_item.opcode)
                dmn_pkg::OP_LOCAL_REQ: begin
                    if (!r_wanting && !r_inside) begin
                        n_clock          = loc_clock;
                        n_req_stamp      = loc_clock;
                        n_wanting        = 1'b1;
                        n_grant          = 3'd0;
                        o_push           = 1'b1;
                        o_job.first_mask = others;
                        o_job.first_kind = dmn_pkg::KIND_REQUEST;
                        o_job.stamp      = dmn_pkg::STAMP_BITS'(WB'(loc_clock));
                    end
                end
                dmn_pkg::OP_LOCAL_REL: begin
                    if (r_wanting || r_inside) begin
                        n_wanting         = 1'b0;
                        n_inside          = 1'b0;
                        n_deferred        = '0;
                        o_push            = 1'b1;
                        o_job.first_mask  = r_deferred & lt_n;
                        o_job.first_kind  = dmn_pkg::KIND_REPLY;
                        o_job.second_mask = others;
                        o_job.stamp       = dmn_pkg::STAMP_BITS'(WB'(r_clock));
                    end
                end
                dmn_pkg::OP_GOT_REQ: begin
                    n_clock = rx_clock;
                    if (|(others & src_bit)) begin
                        if (defer_req) begin
                            n_deferred = r_deferred | src_bit;
                        end else begin
                            o_push           = 1'b1;
                            o_job.first_mask = src_bit;
                            o_job.first_kind = dmn_pkg::KIND_REPLY;
                            o_job.stamp      = dmn_pkg::STAMP_BITS'(WB'(rx_clock));
                        end
                    end
                end
                dmn_pkg::OP_GOT_REPLY: begin
                    n_clock = rx_clock;
                    if ((|(others & src_bit)) && r_wanting && !r_inside) begin
                        n_grant = r_grant + 3'd1;
                        if (({1'b0, r_grant} + 4'd1) >= other_cnt) begin
                            n_inside         = 1'b1;
                            o_push           = 1'b1;
                            o_job.first_mask = dmn_pkg::RANK_SLOTS'(1) << r_own_rank;
                            o_job.first_kind = dmn_pkg::KIND_ENTER;
                            o_job.stamp      = dmn_pkg::STAMP_BITS'(WB'(rx_clock));
                        end
                    end
                end
                dmn_pkg::OP_GOT_REL: begin
                    n_clock = rx_clock;
                end
                default: begin
                end
            endcase
        end
    end

    // protocol state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 4'd2;
            r_own_rank   <= '0;
            r_clock      <= '0;
            r_req_stamp  <= '0;
            r_wanting    <= 1'b0;
            r_inside     <= 1'b0;
            r_grant      <= 3'd0;
            r_deferred   <= '0;
        end else begin
            r_clock     <= n_clock;
            r_req_stamp <= n_req_stamp;
            r_wanting   <= n_wanting;
            r_inside    <= n_inside;
            r_grant     <= n_grant;
            r_deferred  <= n_deferred;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dmn_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    dmn_pkg::CFG_OWN_RANK:   r_own_rank   <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/dmn_back.sv
// ----------------------------------------------------------------------------
// dmn_back
// Takes jobs from the queue and sends their messages one per cycle while the
// receiver does not stall, lowest rank first, through an output register.
// ----------------------------------------------------------------------------
module dmn_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmn_pkg::t_job      i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    output dmn_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic [dmn_pkg::RANK_SLOTS-1:0] r_mask1, n_mask1;
    logic [dmn_pkg::RANK_SLOTS-1:0] r_mask2, n_mask2;
    logic [1:0]                     r_kind1, n_kind1;
    logic [dmn_pkg::STAMP_BITS-1:0] r_stamp, n_stamp;
    logic                           r_valid, n_valid;
    dmn_pkg::t_out_item             r_out,   n_out;

    logic                           busy;
    logic                           advance;
    logic [dmn_pkg::RANK_SLOTS-1:0] rest1;
    logic [dmn_pkg::RANK_SLOTS-1:0] rest2;

    assign o_valid = r_valid;
    assign o_item  = r_out;

    // step through the job masks
    always_comb begin
        busy    = (|r_mask1) || (|r_mask2);
        advance = busy && (!r_valid || !i_stall);
        o_pop   = !busy && !i_empty;
        rest1   = r_mask1 & (r_mask1 - dmn_pkg::RANK_SLOTS'(1));
        rest2   = r_mask2 & (r_mask2 - dmn_pkg::RANK_SLOTS'(1));
        n_mask1 = r_mask1;
        n_mask2 = r_mask2;
        n_kind1 = r_kind1;
        n_stamp = r_stamp;
        n_out   = r_out;
        n_valid = r_valid && i_stall;
        if (o_pop) begin
            n_mask1 = i_job.first_mask;
            n_mask2 = i_job.second_mask;
            n_kind1 = i_job.first_kind;
            n_stamp = i_job.stamp;
        end else if (advance) begin
            n_valid     = 1'b1;
            n_out.stamp = r_stamp;
            if (|r_mask1) begin
                n_out.kind = r_kind1;
                n_out.dest = dmn_pkg::lowest_rank(r_mask1);
                n_out.last = (rest1 == '0) && (r_mask2 == '0);
                n_mask1    = rest1;
            end else begin
                n_out.kind = dmn_pkg::KIND_RELEASE;
                n_out.dest = dmn_pkg::lowest_rank(r_mask2);
                n_out.last = (rest2 == '0);
                n_mask2    = rest2;
            end
        end
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask1 <= '0;
            r_mask2 <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask1 <= n_mask1;
            r_mask2 <= n_mask2;
            r_valid <= n_valid;
        end
        r_kind1 <= n_kind1;
        r_stamp <= n_stamp;
        r_out   <= n_out;
    end

endmodule

FILE: rtl/distributed_mutex_node.sv
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala mutual exclusion with a Lamport clock.
// ----------------------------------------------------------------------------
// The front takes one item per cycle while the two-entry job queue has room,
// updates the clock and protocol state at once, and queues the messages the
// item causes. The back first loads a job into its sequencer registers and
// then sends one message per cycle unless the receiver stalls: a local
// release gives up to fourteen results, a local request up to seven, and a
// reply or entry one. The back's one-message-per-cycle sequencer sets the
// rate; stall on the input rises only while the queue is full.
module distributed_mutex_node #(
    parameter int MAX_NODES  = 8,
    parameter int CLOCK_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_valid,
    input  dmn_pkg::t_in_item  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output dmn_pkg::t_out_item o_data,
    input  logic               i_stall
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    dmn_pkg::t_job push_job;
    dmn_pkg::t_job head_job;

    // input side handshake
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    dmn_front #(
        .MAX_NODES  (MAX_NODES),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_data),
        .o_push     (push),
        .o_job      (push_job)
    );

    dmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dmn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (o_data),
        .i_stall (i_stall)
    );

endmodule

FILE: tb/sv/distributed_mutex_node_tb.sv
// ----------------------------------------------------------------------------
// distributed_mutex_node_tb
// Self-checking bench for one mutual exclusion node. A queue of pending items,
// register writes and idling modes feeds a clocked driver. An in-bench model of
// the Lamport clock and request/deferral protocol predicts every message. A
// clocked monitor checks each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module distributed_mutex_node_tb;

    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SEG_HALF      = 12;
    localparam int NODE_LIMIT    = dmn_pkg::RANK_SLOTS;
    localparam logic [15:0] STAMP_TOP = 16'hFFFF;

    // what one pending entry asks of the driver
    typedef enum logic [1:0] {
        ENT_ITEM,
        ENT_CFG,
        ENT_DRAIN,
        ENT_MODE
    } t_ent_kind;

    typedef struct packed {
        t_ent_kind         what;
        dmn_pkg::t_in_item item;
        logic              idx;
        logic [3:0]        val;
        logic [6:0]        idle;
        logic [6:0]        stall;
    } t_entry;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic               i_cfg_idx  = 1'b0;
    logic [3:0]         i_cfg_data = '0;
    logic               i_valid    = 1'b0;
    dmn_pkg::t_in_item  i_data     = '0;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    dmn_pkg::t_out_item o_data;

    t_entry             pending[$];
    dmn_pkg::t_out_item due_msgs[$];
    int                 error_count  = 0;
    int                 idle_pct     = 0;
    int                 stall_pct    = 0;
    int                 quiet_cycles = 0;

    // node state as the bench sees it
    logic [3:0]  cnt_reg;
    logic [2:0]  rank_reg;
    logic [15:0] lam_clock;
    logic [15:0] req_stamp;
    logic        wanting;
    logic        in_cs;
    int          grants;
    logic [7:0]  held_replies;

    // stimulus side view of the configuration and the clock
    logic [3:0] gen_cnt   = 4'd2;
    logic [2:0] gen_rank  = 3'd0;
    int         gen_hint  = 0;
    int         busy_items = 0;

    distributed_mutex_node dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // node model
    // ------------------------------------------------------------------

    function automatic int active_nodes(logic [3:0] cnt);
        if (cnt < 2) return 2;
        if (cnt > NODE_LIMIT) return NODE_LIMIT;
        return int'(cnt);
    endfunction

    function automatic logic [15:0] bump(logic [15:0] c);
        return (c == STAMP_TOP) ? STAMP_TOP : c + 16'd1;
    endfunction

    function automatic bit is_peer(int rank, int n);
        return rank < n && rank != int'(rank_reg);
    endfunction

    function automatic void post_msg(logic [1:0] kind, int dest);
        dmn_pkg::t_out_item m;
        m.kind  = kind;
        m.dest  = 3'(dest);
        m.stamp = lam_clock;
        m.last  = 1'b0;
        due_msgs.push_back(m);
    endfunction

    function automatic void load_register(logic idx, logic [3:0] val);
        if (idx == dmn_pkg::CFG_NODE_COUNT) cnt_reg = val;
        else rank_reg = val[2:0];
    endfunction

    // clock update, protocol step and the messages one item causes
    function automatic void node_react(dmn_pkg::t_in_item it);
        int          n;
        int          i;
        int          src;
        int          depth0;
        logic [15:0] s;
        n      = active_nodes(cnt_reg);
        src    = int'(it.source);
        s      = it.msg_stamp;
        depth0 = due_msgs.size();
        if (it.opcode >= dmn_pkg::OP_GOT_REQ && it.opcode <= dmn_pkg::OP_GOT_REL) begin
            lam_clock = bump(lam_clock > s ? lam_clock : s);
        end
        case (it.opcode)
            dmn_pkg::OP_LOCAL_REQ: begin
                if (!wanting && !in_cs) begin
                    lam_clock = bump(lam_clock);
                    req_stamp = lam_clock;
                    wanting   = 1'b1;
                    grants    = 0;
                    for (i = 0; i < n; i++) begin
                        if (is_peer(i, n)) post_msg(dmn_pkg::KIND_REQUEST, i);
                    end
                end
            end
            dmn_pkg::OP_LOCAL_REL: begin
                if (wanting || in_cs) begin
                    wanting = 1'b0;
                    in_cs   = 1'b0;
                    for (i = 0; i < n; i++) begin
                        if (held_replies[i]) post_msg(dmn_pkg::KIND_REPLY, i);
                    end
                    held_replies = '0;
                    for (i = 0; i < n; i++) begin
                        if (is_peer(i, n)) post_msg(dmn_pkg::KIND_RELEASE, i);
                    end
                end
            end
            dmn_pkg::OP_GOT_REQ: begin
                if (is_peer(src, n)) begin
                    if (in_cs || (wanting && (req_stamp < s ||
                                              (req_stamp == s && int'(rank_reg) < src)))) begin
                        held_replies[src] = 1'b1;
                    end else begin
                        post_msg(dmn_pkg::KIND_REPLY, src);
                    end
                end
            end
            dmn_pkg::OP_GOT_REPLY: begin
                if (is_peer(src, n) && wanting && !in_cs) begin
                    grants++;
                    if (grants >= ((int'(rank_reg) < n) ? n - 1 : n)) begin
                        in_cs = 1'b1;
                        post_msg(dmn_pkg::KIND_ENTER, int'(rank_reg));
                    end
                end
            end
            default: ;
        endcase
        if (due_msgs.size() > depth0) due_msgs[due_msgs.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic logic [15:0] clamp_stamp(int v);
        if (v < 0) return 16'd0;
        if (v > int'(STAMP_TOP)) return STAMP_TOP;
        return 16'(v);
    endfunction

    function automatic logic [15:0] near_hint(int spread);
        return clamp_stamp(gen_hint + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic void push_item(logic [2:0] op, logic [2:0] src, logic [15:0] stamp);
        t_entry e;
        e = '0;
        e.what = ENT_ITEM;
        e.item.opcode    = op;
        e.item.source    = src;
        e.item.msg_stamp = stamp;
        pending.push_back(e);
        // rough track of the node's clock so stamps land near it
        if (op >= dmn_pkg::OP_GOT_REQ && op <= dmn_pkg::OP_GOT_REL) begin
            gen_hint = int'(clamp_stamp((gen_hint > int'(stamp) ? gen_hint : int'(stamp)) + 1));
        end else if (op == dmn_pkg::OP_LOCAL_REQ) begin
            gen_hint = int'(clamp_stamp(gen_hint + 1));
        end
        if (op <= dmn_pkg::OP_GOT_REL) busy_items++;
    endfunction

    function automatic void push_cfg(logic idx, logic [3:0] val);
        t_entry e;
        e = '0;
        e.what = ENT_CFG;
        e.idx  = idx;
        e.val  = val;
        pending.push_back(e);
        if (idx == dmn_pkg::CFG_NODE_COUNT) gen_cnt = val;
        else gen_rank = val[2:0];
    endfunction

    function automatic void push_ctrl(t_ent_kind what, int idle, int stall);
        t_entry e;
        e = '0;
        e.what  = what;
        e.idle  = 7'(idle);
        e.stall = 7'(stall);
        pending.push_back(e);
    endfunction

    // one request, grant, critical section and release exchange
    function automatic void push_round();
        int n;
        int i;
        int j;
        int tmp;
        int req;
        int cut;
        bit withdraw;
        int peers[$];
        n = active_nodes(gen_cnt);
        for (i = 0; i < n; i++) if (i != int'(gen_rank)) peers.push_back(i);
        for (i = peers.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = peers[i];
            peers[i] = peers[j];
            peers[j] = tmp;
        end
        push_item(dmn_pkg::OP_LOCAL_REQ, 3'($urandom), 16'($urandom));
        req      = gen_hint;
        withdraw = $urandom_range(99) < 15;
        cut      = withdraw ? $urandom_range(0, peers.size() - 1) : peers.size();
        for (i = 0; i < cut; i++) begin
            // competing requests with stamps on both sides of ours
            if ($urandom_range(99) < 40) begin
                push_item(dmn_pkg::OP_GOT_REQ, 3'(peers[$urandom_range(0, peers.size() - 1)]),
                          clamp_stamp(req + int'($urandom_range(0, 6)) - 3));
            end
            push_item(dmn_pkg::OP_GOT_REPLY, 3'(peers[i]), near_hint(4));
        end
        if (!withdraw) begin
            repeat ($urandom_range(0, 2)) begin
                push_item(dmn_pkg::OP_GOT_REQ, 3'(peers[$urandom_range(0, peers.size() - 1)]),
                          near_hint(4));
            end
        end
        push_item(dmn_pkg::OP_LOCAL_REL, 3'($urandom), 16'($urandom));
        repeat ($urandom_range(0, peers.size())) begin
            push_item(dmn_pkg::OP_GOT_REL, 3'($urandom), near_hint(3));
        end
    endfunction

    // anything the fields allow
    function automatic void push_noise();
        logic [2:0]  op;
        logic [15:0] stamp;
        op = 3'($urandom);
        if (op >= dmn_pkg::OP_GOT_REQ && op <= dmn_pkg::OP_GOT_REL) begin
            stamp = ($urandom_range(99) < 30) ? 16'($urandom_range(0, gen_hint)) : near_hint(6);
        end else begin
            stamp = 16'($urandom);
        end
        push_item(op, 3'($urandom), stamp);
    endfunction

    function automatic void add_traffic();
        if ($urandom_range(99) < 25) push_noise();
        else push_round();
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_entry            head;
        logic              nxt_valid;
        dmn_pkg::t_in_item nxt_data;
        logic              nxt_we;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_data       <= '0;
            i_cfg_we     <= 1'b0;
            i_cfg_idx    <= 1'b0;
            i_cfg_data   <= '0;
            cnt_reg      = 4'd2;
            rank_reg     = 3'd0;
            lam_clock    = '0;
            req_stamp    = '0;
            wanting      = 1'b0;
            in_cs        = 1'b0;
            grants       = 0;
            held_replies = '0;
            quiet_cycles = 0;
        end else begin
            nxt_valid = i_valid;
            nxt_data  = i_data;
            nxt_we    = 1'b0;
            if (i_cfg_we) load_register(i_cfg_idx, i_cfg_data);
            if (i_valid && !o_stall) begin
                node_react(i_data);
                nxt_valid = 1'b0;
            end
            // register writes wait for a quiet block
            if (nxt_valid || i_cfg_we || due_msgs.size() != 0) quiet_cycles = 0;
            else quiet_cycles++;
            if (!nxt_valid && pending.size() != 0) begin
                head = pending[0];
                case (head.what)
                    ENT_ITEM: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            nxt_valid = 1'b1;
                            nxt_data  = head.item;
                            void'(pending.pop_front());
                        end
                    end
                    ENT_MODE: begin
                        idle_pct  = int'(head.idle);
                        stall_pct = int'(head.stall);
                        void'(pending.pop_front());
                    end
                    ENT_DRAIN: begin
                        if (due_msgs.size() == 0) void'(pending.pop_front());
                    end
                    ENT_CFG: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            nxt_we       = 1'b1;
                            i_cfg_idx    <= head.idx;
                            i_cfg_data   <= head.val;
                            quiet_cycles = 0;
                            void'(pending.pop_front());
                        end
                    end
                    default: ;
                endcase
            end
            i_valid  <= nxt_valid;
            i_data   <= nxt_data;
            i_cfg_we <= nxt_we;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dmn_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_msgs.size() == 0) begin
                $error("unexpected result kind=%0d dest=%0d stamp=%0d last=%0d",
                       o_data.kind, o_data.dest, o_data.stamp, o_data.last);
                error_count++;
            end else begin
                want = due_msgs.pop_front();
                if (o_data.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_data.kind);
                    error_count++;
                end
                if (o_data.dest != want.dest) begin
                    $error("dest: expected %0d, got %0d", want.dest, o_data.dest);
                    error_count++;
                end
                if (o_data.stamp != want.stamp) begin
                    $error("stamp: expected %0d, got %0d", want.stamp, o_data.stamp);
                    error_count++;
                end
                if (o_data.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_data.last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] seg_cnt  [8];
        logic [2:0] seg_rank [8];
        int         k;
        int         seg;
        int         req;
        int         goal;
        seg_cnt  = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd1, 4'd7, 4'd2};
        seg_rank = '{3'd7, 3'd0, 3'd3,  3'd6, 3'd2, 3'd1, 3'd0, 3'd5};

        // directed: four nodes, this one is rank 1
        push_cfg(dmn_pkg::CFG_NODE_COUNT, 4'd4);
        push_cfg(dmn_pkg::CFG_OWN_RANK, 4'd1);
        push_item(dmn_pkg::OP_GOT_REL, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_GOT_REQ, 3'd3, 16'd5);       // idle node answers at once
        push_item(dmn_pkg::OP_GOT_REQ, 3'd1, 16'd0);       // request from own rank
        push_item(dmn_pkg::OP_GOT_REQ, 3'd6, 16'd0);       // source beyond the node count
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd0, 16'd0);     // stray reply
        push_item(dmn_pkg::OP_LOCAL_REL, 3'd0, 16'd0);     // release with nothing held
        for (k = 1; k <= 3; k++) push_item(3'(dmn_pkg::OP_GOT_REL + k), 3'd7, STAMP_TOP);
        push_item(dmn_pkg::OP_LOCAL_REQ, 3'd0, 16'd0);
        req = gen_hint;
        push_item(dmn_pkg::OP_LOCAL_REQ, 3'd0, 16'd0);     // repeated request
        push_item(dmn_pkg::OP_GOT_REQ, 3'd0, 16'(req - 7)); // older request wins
        push_item(dmn_pkg::OP_GOT_REQ, 3'd3, 16'(req));    // tie, our lower rank wins
        push_item(dmn_pkg::OP_GOT_REQ, 3'd0, 16'(req));    // tie, their lower rank wins
        push_item(dmn_pkg::OP_GOT_REQ, 3'd2, 16'(req + 30));
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd2, 16'd0);
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd3, 16'd0);     // last grant, entry
        push_item(dmn_pkg::OP_GOT_REQ, 3'd0, 16'd0);       // held while in the critical section
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd3, 16'd0);     // reply while already inside
        push_item(dmn_pkg::OP_LOCAL_REL, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_LOCAL_REQ, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_LOCAL_REL, 3'd0, 16'd0);     // withdraw before entry
        push_item(dmn_pkg::OP_GOT_REL, 3'd7, 16'd0);

        // random segments, each with its own settings and idling mode
        for (seg = 0; seg < 8; seg++) begin
            if (seg == 7) begin
                push_cfg(dmn_pkg::CFG_NODE_COUNT, 4'($urandom));
                push_cfg(dmn_pkg::CFG_OWN_RANK, 4'($urandom_range(0, 7)));
            end else begin
                push_cfg(dmn_pkg::CFG_NODE_COUNT, seg_cnt[seg]);
                push_cfg(dmn_pkg::CFG_OWN_RANK, {1'b0, seg_rank[seg]});
            end
            case (seg % 4)
                0: push_ctrl(ENT_MODE, 0, 0);
                1: push_ctrl(ENT_MODE, 84, 0);
                2: push_ctrl(ENT_MODE, 0, 84);
                default: push_ctrl(ENT_MODE, 8, 8);
            endcase
            goal = busy_items + SEG_HALF;
            while (busy_items < goal) add_traffic();
            // sender holds off until every message is out
            push_ctrl(ENT_DRAIN, 0, 0);
            goal = busy_items + SEG_HALF;
            while (busy_items < goal) add_traffic();
        end

        // clock at its maximum, tie broken by rank at the top stamp
        push_cfg(dmn_pkg::CFG_NODE_COUNT, 4'd4);
        push_cfg(dmn_pkg::CFG_OWN_RANK, 4'd1);
        push_ctrl(ENT_MODE, 0, 0);
        push_item(dmn_pkg::OP_GOT_REL, 3'd7, 16'hFFFE);
        push_item(dmn_pkg::OP_GOT_REQ, 3'd0, STAMP_TOP);
        push_item(dmn_pkg::OP_LOCAL_REL, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_LOCAL_REQ, 3'd0, 16'd0);
        push_item(dmn_pkg::OP_GOT_REQ, 3'd3, STAMP_TOP);
        push_item(dmn_pkg::OP_GOT_REQ, 3'd0, STAMP_TOP);
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd0, STAMP_TOP);
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd2, STAMP_TOP);
        push_item(dmn_pkg::OP_GOT_REPLY, 3'd3, STAMP_TOP);
        push_item(dmn_pkg::OP_LOCAL_REL, 3'd0, 16'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_valid || due_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("distributed_mutex_node_tb passed");
        end else begin
            $display("distributed_mutex_node_tb failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("distributed_mutex_node_tb failed");
        $finish;
    end

endmodule
